// ===== hw/rtl/nnm_pkg.sv =====
package nnm_pkg;

    // Field widths of the item and result beats and of the robot count
    localparam int INDEX_BITS = 9;
    localparam int COORD_FIELD_BITS = 10;
    localparam int DIST_BITS = 21;
    localparam int COUNT_BITS = 9;

    // Operation codes
    localparam logic [1:0] OP_LOAD_RELAY = 2'd0;
    localparam logic [1:0] OP_LOAD_MOBILE = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]                  operation;
        logic [INDEX_BITS-1:0]       node_index;
        logic [COORD_FIELD_BITS-1:0] coord_x;
        logic [COORD_FIELD_BITS-1:0] coord_y;
        logic [INDEX_BITS-1:0]       first_endpoint;
        logic [INDEX_BITS-1:0]       second_endpoint;
    } nnm_item_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] nearest_relay;
        logic [DIST_BITS-1:0]  best_distance;
        logic                  found;
    } nnm_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_A,
        ST_READ_B,
        ST_MIDPOINT,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } nnm_state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;         // item beat accepted this cycle
        logic read_second;  // address mobile table with second endpoint
        logic capture_a;    // latch first endpoint coordinates
        logic capture_mid;  // latch midpoint, arm scan
        logic issue;        // read next relay entry
        logic load_result;  // move best match into output register
    } nnm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic item_is_query;
        logic limit_zero;
        logic last_issue;
        logic pipe_busy;
    } nnm_status_t;

endpackage

// ===== hw/rtl/nnm_datapath.sv =====
module nnm_datapath #(
    parameter int RELAY_ENTRIES = 256,
    parameter int MOBILE_ENTRIES = 256,
    parameter int COORD_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nnm_pkg::nnm_item_t                  item,
    input  logic                                item_valid,
    input  logic                                cfg_valid,
    input  logic [nnm_pkg::COUNT_BITS-1:0]      cfg_data,
    input  nnm_pkg::nnm_cmd_t                   cmd,
    output nnm_pkg::nnm_status_t                status,
    output nnm_pkg::nnm_result_t                result
);

    localparam int CW = (COORD_BITS < nnm_pkg::COORD_FIELD_BITS) ?
                        COORD_BITS : nnm_pkg::COORD_FIELD_BITS;
    localparam int SW = 2 * CW;
    localparam int DW = SW + 1;
    localparam int RA = (RELAY_ENTRIES > 1) ? $clog2(RELAY_ENTRIES) : 1;
    localparam int MA = (MOBILE_ENTRIES > 1) ? $clog2(MOBILE_ENTRIES) : 1;
    localparam int IB = nnm_pkg::INDEX_BITS;

    logic [2*CW-1:0] relay_mem [RELAY_ENTRIES];
    logic [2*CW-1:0] mobile_mem [MOBILE_ENTRIES];

    logic [nnm_pkg::COUNT_BITS-1:0] robot_count_reg;
    logic [IB-1:0]    first_reg, second_reg;
    logic [IB-1:0]    limit_reg, limit_next;
    logic [IB-1:0]    scan_cnt_reg;
    logic [2*CW-1:0]  mob_rdata_reg, rel_rdata_reg;
    logic [CW-1:0]    ax_reg, ay_reg, mx_reg, my_reg;
    logic             v1_reg, v2_reg;
    logic [IB-1:0]    tag1_reg, tag2_reg;
    logic [SW-1:0]    sqx_reg, sqy_reg;
    logic [DW-1:0]    best_reg;
    logic [IB-1:0]    best_idx_reg;
    logic             have_reg;
    nnm_pkg::nnm_result_t result_reg;

    logic            relay_we, mobile_we;
    logic            relay_ok, mobile_ok, first_ok, second_ok;
    logic [RA-1:0]   relay_waddr, relay_raddr;
    logic [MA-1:0]   mobile_waddr, mobile_raddr;
    logic [IB-1:0]   sel_endpoint;
    logic [CW-1:0]   bx, by, rx, ry, dx, dy;
    logic [DW-1:0]   dist_sum;

    // Load decode
    assign relay_ok = (item.node_index != '0) &&
                      (32'(item.node_index) <= RELAY_ENTRIES);
    assign mobile_ok = (item.node_index != '0) &&
                       (32'(item.node_index) <= MOBILE_ENTRIES);
    assign relay_we = cmd.take && (item.operation == nnm_pkg::OP_LOAD_RELAY) && relay_ok;
    assign mobile_we = cmd.take && (item.operation == nnm_pkg::OP_LOAD_MOBILE) && mobile_ok;
    assign relay_waddr = RA'(item.node_index - 1'b1);
    assign mobile_waddr = MA'(item.node_index - 1'b1);

    assign first_ok = (first_reg != '0) && (32'(first_reg) <= MOBILE_ENTRIES);
    assign second_ok = (second_reg != '0) && (32'(second_reg) <= MOBILE_ENTRIES);
    assign sel_endpoint = cmd.read_second ? second_reg : first_reg;
    assign mobile_raddr = MA'(sel_endpoint - 1'b1);
    assign relay_raddr = RA'(scan_cnt_reg - 1'b1);

    always_ff @(posedge clk)
    begin
        if (relay_we)
        begin
            relay_mem[relay_waddr] <= {item.coord_x[CW-1:0], item.coord_y[CW-1:0]};
        end
        rel_rdata_reg <= relay_mem[relay_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (mobile_we)
        begin
            mobile_mem[mobile_waddr] <= {item.coord_x[CW-1:0], item.coord_y[CW-1:0]};
        end
        mob_rdata_reg <= mobile_mem[mobile_raddr];
    end

    // Saturate the count at the table depth
    always_comb
    begin
        if (32'(robot_count_reg) > RELAY_ENTRIES)
        begin
            limit_next = IB'(RELAY_ENTRIES);
        end
        else
        begin
            limit_next = IB'(robot_count_reg);
        end
    end

    assign bx = second_ok ? mob_rdata_reg[2*CW-1:CW] : '0;
    assign by = second_ok ? mob_rdata_reg[CW-1:0] : '0;
    assign rx = rel_rdata_reg[2*CW-1:CW];
    assign ry = rel_rdata_reg[CW-1:0];
    assign dx = (mx_reg >= rx) ? (mx_reg - rx) : (rx - mx_reg);
    assign dy = (my_reg >= ry) ? (my_reg - ry) : (ry - my_reg);
    assign dist_sum = DW'(sqx_reg) + DW'(sqy_reg);

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            first_reg <= item.first_endpoint;
            second_reg <= item.second_endpoint;
            limit_reg <= limit_next;
        end
        if (cmd.capture_a)
        begin
            ax_reg <= first_ok ? mob_rdata_reg[2*CW-1:CW] : '0;
            ay_reg <= first_ok ? mob_rdata_reg[CW-1:0] : '0;
        end
        if (cmd.capture_mid)
        begin
            mx_reg <= CW'(((CW+1)'(ax_reg) + (CW+1)'(bx)) >> 1);
            my_reg <= CW'(((CW+1)'(ay_reg) + (CW+1)'(by)) >> 1);
        end
        tag1_reg <= scan_cnt_reg;
        tag2_reg <= tag1_reg;
        sqx_reg <= SW'(dx * dx);
        sqy_reg <= SW'(dy * dy);
        if (cmd.capture_mid)
        begin
            best_reg <= '0;
            best_idx_reg <= '0;
        end
        else if (v2_reg && (!have_reg || dist_sum < best_reg))
        begin
            best_reg <= dist_sum;
            best_idx_reg <= tag2_reg;
        end
        if (cmd.load_result)
        begin
            result_reg.nearest_relay <= best_idx_reg;
            result_reg.best_distance <= nnm_pkg::DIST_BITS'(best_reg);
            result_reg.found <= have_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            robot_count_reg <= '0;
            scan_cnt_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            have_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                robot_count_reg <= cfg_data;
            end
            if (cmd.capture_mid)
            begin
                scan_cnt_reg <= IB'(1);
            end
            else if (cmd.issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (cmd.capture_mid)
            begin
                have_reg <= 1'b0;
            end
            else if (v2_reg)
            begin
                have_reg <= 1'b1;
            end
        end
    end

    assign status.item_is_query = item_valid && (item.operation == nnm_pkg::OP_QUERY);
    assign status.limit_zero = (limit_reg == '0);
    assign status.last_issue = (scan_cnt_reg == limit_reg);
    assign status.pipe_busy = v1_reg || v2_reg;
    assign result = result_reg;

    // A running minimum never rises
    a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && have_reg && !cmd.capture_mid |=> best_reg <= $past(best_reg))
        else $error("best distance rose during a scan");

    // Entries reach the compare stage in consecutive order
    a_tag_order: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && v1_reg |=> tag2_reg == IB'($past(tag2_reg) + 1'b1))
        else $error("relay entries out of order in compare stage");

    // A match always carries a real entry number
    a_match_index: assert property (@(posedge clk) disable iff (!rst_n)
        have_reg && !cmd.capture_mid |-> best_idx_reg != '0)
        else $error("match recorded with entry number zero");

endmodule

// ===== hw/rtl/nnm_controller.sv =====
module nnm_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    output logic                  result_valid,
    input  logic                  result_ready,
    input  nnm_pkg::nnm_status_t  status,
    output nnm_pkg::nnm_cmd_t     cmd
);

    nnm_pkg::nnm_state_t state_reg, state_next;
    logic result_valid_reg, result_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nnm_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            nnm_pkg::ST_IDLE:
            begin
                cmd.take = item_valid;
                if (status.item_is_query)
                begin
                    state_next = nnm_pkg::ST_READ_A;
                end
            end
            nnm_pkg::ST_READ_A:
            begin
                state_next = nnm_pkg::ST_READ_B;
            end
            nnm_pkg::ST_READ_B:
            begin
                cmd.read_second = 1'b1;
                cmd.capture_a = 1'b1;
                state_next = nnm_pkg::ST_MIDPOINT;
            end
            nnm_pkg::ST_MIDPOINT:
            begin
                cmd.capture_mid = 1'b1;
                state_next = nnm_pkg::ST_SCAN;
            end
            nnm_pkg::ST_SCAN:
            begin
                if (status.limit_zero)
                begin
                    state_next = nnm_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.issue = 1'b1;
                    if (status.last_issue)
                    begin
                        state_next = nnm_pkg::ST_DRAIN;
                    end
                end
            end
            nnm_pkg::ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = nnm_pkg::ST_FINISH;
                end
            end
            nnm_pkg::ST_FINISH:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    cmd.load_result = 1'b1;
                    state_next = nnm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nnm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_result)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    assign item_ready = (state_reg == nnm_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;

    // Never overwrite a result beat that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> (!result_valid_reg || result_ready))
        else $error("result register overwritten before delivery");

    // Leave the drain only once the compare pipeline is empty
    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == nnm_pkg::ST_DRAIN && state_next == nnm_pkg::ST_FINISH
        |-> !status.pipe_busy)
        else $error("result taken with scan still in flight");

endmodule

// ===== hw/rtl/nearest_node_to_midpoint.sv =====
// Nearest relay node to the midpoint of a link between two mobile nodes.
// Item beats either load one relay or mobile coordinate entry (1-based
// node_index; an index of zero or beyond the table is dropped) or ask a
// query; only a query produces a result beat. A query reads the two named
// mobile entries, forms the per-axis midpoint rounded down (an endpoint out
// of range counts as the origin) and scans relay entries 1 to robot_count
// (saturated at RELAY_ENTRIES) for the smallest squared distance, the lowest
// entry winning a tie; with robot_count zero the result reports found = 0
// and zeros. A load or unused operation leaves the block idle; a query
// keeps item_ready low through its read, midpoint, scan, drain (none when
// the count is zero) and finish states until its result is loaded. The
// relay table has one read port, and the scan reads one entry a cycle
// through a three-stage pipeline: table read, square, then sum and compare.
// The result sits in an output register, so the next item is taken while a
// result beat waits; a following query holds in its finish state until
// that beat goes. Tables are not cleared at reset: read only entries that
// have been loaded. Write robot_count on the cfg channel while the block is
// idle; it is always ready.
module nearest_node_to_midpoint #(
    parameter int RELAY_ENTRIES = 256,
    parameter int MOBILE_ENTRIES = 256,
    parameter int COORD_BITS = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  nnm_pkg::nnm_item_t              item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output nnm_pkg::nnm_result_t            result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nnm_pkg::COUNT_BITS-1:0]  cfg_data
);

    nnm_pkg::nnm_cmd_t    cmd;
    nnm_pkg::nnm_status_t status;

    // Sequencer: handshakes, query phases and the result register valid
    nnm_controller u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // Coordinate tables, midpoint and distance pipeline
    nnm_datapath #(
        .RELAY_ENTRIES  (RELAY_ENTRIES),
        .MOBILE_ENTRIES (MOBILE_ENTRIES),
        .COORD_BITS     (COORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .status     (status),
        .result     (result)
    );

    // The count register takes a write in any cycle
    assign cfg_ready = 1'b1;

endmodule

// ===== dv/tb_nearest_node_to_midpoint.sv =====
module tb_nearest_node_to_midpoint;

    // Both coordinate tables hold this many 1-based entries
    localparam int TABLE_DEPTH = 256;
    localparam int COORD_MAX = 1023;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Time for a query over the full table to finish, with a margin on top
    localparam int SETTLE_CYCLES = 300;
    // Receiver hold-off long enough for the block to fill and stall its item side
    localparam int LONG_HOLD = 400;
    // Random phases and the counted items in each
    localparam int PHASES = 14;
    localparam int PHASE_ITEMS = 55;
    // Watchdog limit, several times the slowest legal run
    localparam int RUN_LIMIT = 3000000;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    // One row of the directed table: either an item beat or a robot_count write.
    // Where typed is set, want is the hand-worked result; otherwise the predictor decides.
    typedef struct packed {
        row_kind_t                      kind;
        logic [1:0]                     op;
        logic [nnm_pkg::INDEX_BITS-1:0] idx;
        logic [9:0]                     x;
        logic [9:0]                     y;
        logic [nnm_pkg::INDEX_BITS-1:0] a;
        logic [nnm_pkg::INDEX_BITS-1:0] b;
        logic [nnm_pkg::COUNT_BITS-1:0] cfg;
        logic                           typed;
        nnm_pkg::nnm_result_t           want;
    } directed_row_t;

    localparam nnm_pkg::nnm_result_t NONE_FOUND = '0;
    localparam nnm_pkg::nnm_result_t FAR_CORNER = '{9'd1, 21'd2093058, 1'b1};
    localparam nnm_pkg::nnm_result_t FIRST_EXACT = '{9'd1, 21'd0, 1'b1};
    localparam nnm_pkg::nnm_result_t SECOND_EXACT = '{9'd2, 21'd0, 1'b1};

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           item_valid = 1'b0;
    logic                           item_ready;
    nnm_pkg::nnm_item_t             item = '0;
    logic                           result_valid;
    logic                           result_ready = 1'b0;
    nnm_pkg::nnm_result_t           result;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [nnm_pkg::COUNT_BITS-1:0] cfg_data = '0;

    // Shadow copy of the block: both tables, the search count and which entries
    // have been loaded, so that no query ever touches an unloaded entry
    logic [9:0]                     relay_x [TABLE_DEPTH];
    logic [9:0]                     relay_y [TABLE_DEPTH];
    logic [9:0]                     mobile_x [TABLE_DEPTH];
    logic [9:0]                     mobile_y [TABLE_DEPTH];
    bit                             relay_loaded [TABLE_DEPTH];
    bit                             mobile_loaded [TABLE_DEPTH];
    int unsigned                    mobile_known [$];
    logic [nnm_pkg::COUNT_BITS-1:0] robot_limit = '0;

    // Results still owed by the block, oldest first
    nnm_pkg::nnm_result_t           pending_nearest [$];
    int unsigned                    mismatches = 0;
    int unsigned                    results_taken = 0;
    bit                             sender_calm = 1'b0;
    bit                             receiver_calm = 1'b0;

    int unsigned phase_limits [12] = '{1, 4, 0, 256, 9, 2, 511, 30, 1, 100, 256, 7};

    directed_row_t directed_rows [23] = '{
        // nothing searched straight after reset; endpoints off the table read as the origin
        '{ROW_ITEM, nnm_pkg::OP_QUERY, 9'd0, 10'd0, 10'd0, 9'd0, 9'd0, 9'd0, 1'b1,
          NONE_FOUND},
        // unused operation with every field at its top: no beat comes back
        '{ROW_ITEM, OP_UNUSED, 9'd511, 10'd1023, 10'd1023, 9'd511, 9'd511, 9'd0, 1'b0,
          NONE_FOUND},
        '{ROW_ITEM, nnm_pkg::OP_LOAD_RELAY, 9'd1, 10'd1023, 10'd1023, 9'd0, 9'd0, 9'd0,
          1'b0, NONE_FOUND},
        '{ROW_ITEM, nnm_pkg::OP_LOAD_RELAY, 9'd2, 10'd0, 10'd0, 9'd0, 9'd0, 9'd0, 1'b0,
          NONE_FOUND},
        '{ROW_ITEM, nnm_pkg::OP_LOAD_RELAY, 9'd3, 10'd0, 10'd0, 9'd0, 9'd0, 9'd0, 1'b0,
          NONE_FOUND},
        // loads off either end of the table are dropped
        '{ROW_ITEM, nnm_pkg::OP_LOAD_RELAY, 9'd0, 10'd5, 10'd5, 9'd0, 9'd0, 9'd0, 1'b0,
          NONE_FOUND},
        '{ROW_ITEM, nnm_pkg::OP_LOAD_RELAY, 9'd511, 10'd7, 10'd7, 9'd0, 9'd0, 9'd0, 1'b0,
          NONE_FOUND},
        '{ROW_ITEM, nnm_pkg::OP_LOAD_MOBILE, 9'd1, 10'd1023, 10'd1023, 9'd0, 9'd0, 9'd0,
          1'b0, NONE_FOUND},
        '{ROW_ITEM, nnm_pkg::OP_LOAD_MOBILE, 9'd2, 10'd0, 10'd0, 9'd0, 9'd0, 9'd0, 1'b0,
          NONE_FOUND},
        '{ROW_ITEM, nnm_pkg::OP_LOAD_MOBILE, 9'd256, 10'd1023, 10'd0, 9'd0, 9'd0, 9'd0,
          1'b0, NONE_FOUND},
        '{ROW_ITEM, nnm_pkg::OP_LOAD_MOBILE, 9'd0, 10'd9, 10'd9, 9'd0, 9'd0, 9'd0, 1'b0,
          NONE_FOUND},
        '{ROW_ITEM, nnm_pkg::OP_LOAD_MOBILE, 9'd300, 10'd9, 10'd9, 9'd0, 9'd0, 9'd0, 1'b0,
          NONE_FOUND},
        '{ROW_CFG, nnm_pkg::OP_LOAD_RELAY, 9'd0, 10'd0, 10'd0, 9'd0, 9'd0, 9'd1, 1'b0,
          NONE_FOUND},
        // origin against the far corner: the largest distance there is
        '{ROW_ITEM, nnm_pkg::OP_QUERY, 9'd0, 10'd0, 10'd0, 9'd0, 9'd0, 9'd0, 1'b1,
          FAR_CORNER},
        '{ROW_ITEM, nnm_pkg::OP_QUERY, 9'd0, 10'd0, 10'd0, 9'd1, 9'd1, 9'd0, 1'b1,
          FIRST_EXACT},
        '{ROW_CFG, nnm_pkg::OP_LOAD_RELAY, 9'd0, 10'd0, 10'd0, 9'd0, 9'd0, 9'd3, 1'b0,
          NONE_FOUND},
        // entries 2 and 3 sit on the same spot: the lower index takes the tie
        '{ROW_ITEM, nnm_pkg::OP_QUERY, 9'd0, 10'd0, 10'd0, 9'd2, 9'd2, 9'd0, 1'b1,
          SECOND_EXACT},
        '{ROW_ITEM, nnm_pkg::OP_QUERY, 9'd0, 10'd0, 10'd0, 9'd1, 9'd2, 9'd0, 1'b0,
          NONE_FOUND},
        '{ROW_ITEM, nnm_pkg::OP_QUERY, 9'd0, 10'd0, 10'd0, 9'd256, 9'd1, 9'd0, 1'b0,
          NONE_FOUND},
        '{ROW_ITEM, nnm_pkg::OP_QUERY, 9'd0, 10'd0, 10'd0, 9'd511, 9'd256, 9'd0, 1'b0,
          NONE_FOUND},
        '{ROW_ITEM, nnm_pkg::OP_QUERY, 9'd0, 10'd0, 10'd0, 9'd257, 9'd0, 9'd0, 1'b1,
          SECOND_EXACT},
        '{ROW_CFG, nnm_pkg::OP_LOAD_RELAY, 9'd0, 10'd0, 10'd0, 9'd0, 9'd0, 9'd0, 1'b0,
          NONE_FOUND},
        '{ROW_ITEM, nnm_pkg::OP_QUERY, 9'd0, 10'd0, 10'd0, 9'd1, 9'd256, 9'd0, 1'b1,
          NONE_FOUND}
    };

    nearest_node_to_midpoint u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic bit on_table(input logic [nnm_pkg::INDEX_BITS-1:0] idx);
        return (idx != 0) && (idx <= 9'(TABLE_DEPTH));
    endfunction

    // Apply one accepted item beat to the shadow tables; return 1 with the
    // expected result when the beat is a query
    function automatic bit predict_nearest(input nnm_pkg::nnm_item_t nxt,
                                           output nnm_pkg::nnm_result_t res);
        int          ax;
        int          ay;
        int          bx;
        int          by;
        int          mx;
        int          my;
        int          dx;
        int          dy;
        int unsigned n;
        int unsigned sq_sum;
        int unsigned best;
        int unsigned best_at;
        res = '0;
        case (nxt.operation)
            nnm_pkg::OP_LOAD_RELAY:
            begin
                if (on_table(nxt.node_index))
                begin
                    relay_x[nxt.node_index - 1] = nxt.coord_x;
                    relay_y[nxt.node_index - 1] = nxt.coord_y;
                    relay_loaded[nxt.node_index - 1] = 1'b1;
                end
            end
            nnm_pkg::OP_LOAD_MOBILE:
            begin
                if (on_table(nxt.node_index))
                begin
                    mobile_x[nxt.node_index - 1] = nxt.coord_x;
                    mobile_y[nxt.node_index - 1] = nxt.coord_y;
                    if (!mobile_loaded[nxt.node_index - 1])
                    begin
                        mobile_loaded[nxt.node_index - 1] = 1'b1;
                        mobile_known.push_back(nxt.node_index);
                    end
                end
            end
            nnm_pkg::OP_QUERY:
            begin
                ax = 0;
                ay = 0;
                bx = 0;
                by = 0;
                // an endpoint off the table counts as the origin
                if (on_table(nxt.first_endpoint))
                begin
                    ax = mobile_x[nxt.first_endpoint - 1];
                    ay = mobile_y[nxt.first_endpoint - 1];
                end
                if (on_table(nxt.second_endpoint))
                begin
                    bx = mobile_x[nxt.second_endpoint - 1];
                    by = mobile_y[nxt.second_endpoint - 1];
                end
                mx = (ax + bx) >> 1;
                my = (ay + by) >> 1;
                // the count saturates at the table depth
                n = (robot_limit > TABLE_DEPTH) ? TABLE_DEPTH : robot_limit;
                best = 0;
                best_at = 0;
                for (int unsigned i = 0; i < n; i++)
                begin
                    dx = mx - int'(relay_x[i]);
                    dy = my - int'(relay_y[i]);
                    sq_sum = dx * dx + dy * dy;
                    // strict less-than keeps the lowest index on a tie
                    if (i == 0 || sq_sum < best)
                    begin
                        best = sq_sum;
                        best_at = i + 1;
                    end
                end
                res.nearest_relay = 9'(best_at);
                res.best_distance = 21'(best);
                res.found = (n != 0);
                return 1'b1;
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    // Favour the corners and a tiny patch near the origin so that ties and
    // duplicate positions turn up often
    function automatic logic [9:0] rand_coord();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 10'd0;
            1: return 10'(COORD_MAX);
            2, 3, 4: return 10'($urandom_range(0, 7));
            default: return 10'($urandom_range(0, COORD_MAX));
        endcase
    endfunction

    // Mostly a loaded mobile entry, now and then one off the table
    function automatic logic [nnm_pkg::INDEX_BITS-1:0] pick_endpoint();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6 || mobile_known.size() == 0)
            return '0;
        if (r < 12)
            return 9'($urandom_range(TABLE_DEPTH + 1, 511));
        return 9'(mobile_known[$urandom_range(0, mobile_known.size() - 1)]);
    endfunction

    // One random item beat for a phase searching `limit` relay entries.
    // Fields a beat does not use are left random.
    function automatic nnm_pkg::nnm_item_t random_item(input int unsigned limit,
                                                       output bit ignored);
        nnm_pkg::nnm_item_t nxt;
        int unsigned        pick;
        int unsigned        r;
        nxt.operation = OP_UNUSED;
        nxt.node_index = 9'($urandom_range(0, 511));
        nxt.coord_x = rand_coord();
        nxt.coord_y = rand_coord();
        nxt.first_endpoint = 9'($urandom_range(0, 511));
        nxt.second_endpoint = 9'($urandom_range(0, 511));
        pick = $urandom_range(0, 99);
        r = $urandom_range(0, 99);
        if (pick < 50)
        begin
            nxt.operation = nnm_pkg::OP_QUERY;
            nxt.first_endpoint = pick_endpoint();
            nxt.second_endpoint = pick_endpoint();
        end
        else if (pick < 72)
        begin
            nxt.operation = nnm_pkg::OP_LOAD_RELAY;
            // aim almost half the relay loads at or just past the searched range
            if (r < 4)
                nxt.node_index = '0;
            else if (r < 8)
                nxt.node_index = 9'($urandom_range(TABLE_DEPTH + 1, 511));
            else if (r < 55)
                nxt.node_index = 9'($urandom_range(1, (limit + 2 > TABLE_DEPTH) ?
                                                      TABLE_DEPTH : limit + 2));
            else
                nxt.node_index = 9'($urandom_range(1, TABLE_DEPTH));
        end
        else if (pick < 92)
        begin
            nxt.operation = nnm_pkg::OP_LOAD_MOBILE;
            if (r < 4)
                nxt.node_index = '0;
            else if (r < 8)
                nxt.node_index = 9'($urandom_range(TABLE_DEPTH + 1, 511));
            else if (r < 60)
                nxt.node_index = 9'($urandom_range(1, 24));
            else
                nxt.node_index = 9'($urandom_range(1, TABLE_DEPTH));
        end
        ignored = (nxt.operation == OP_UNUSED) ||
                  (nxt.operation != nnm_pkg::OP_QUERY && !on_table(nxt.node_index));
        return nxt;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Offer one item beat after a random gap, none when the sender is calm, and
    // hold it until taken; the prediction is made at the edge that accepts it
    task automatic send_item(input nnm_pkg::nnm_item_t nxt, input bit typed,
                             input nnm_pkg::nnm_result_t want);
        int unsigned          gap;
        nnm_pkg::nnm_result_t predicted;
        gap = sender_calm ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= nxt;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        if (predict_nearest(nxt, predicted))
            pending_nearest.push_back(typed ? want : predicted);
    endtask

    // Drop valid, wait for every owed result, then let a full query's worth
    // of cycles pass so that a trailing load has surely landed
    task automatic drain_block();
        item_valid <= 1'b0;
        while (pending_nearest.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_robot_count(input logic [nnm_pkg::COUNT_BITS-1:0] value);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        robot_limit = value;
    endtask

    // Item side: directed table first, then random phases, each under its own count
    initial
    begin : stimulus
        nnm_pkg::nnm_item_t nxt;
        int unsigned        limit;
        int unsigned        searched;
        int unsigned        counted;
        bit                 ignored;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                drain_block();
                write_robot_count(directed_rows[r].cfg);
            end
            else
            begin
                nxt.operation = directed_rows[r].op;
                nxt.node_index = directed_rows[r].idx;
                nxt.coord_x = directed_rows[r].x;
                nxt.coord_y = directed_rows[r].y;
                nxt.first_endpoint = directed_rows[r].a;
                nxt.second_endpoint = directed_rows[r].b;
                send_item(nxt, directed_rows[r].typed, directed_rows[r].want);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            limit = (p < 12) ? phase_limits[p] : $urandom_range(0, 40);
            drain_block();
            write_robot_count(9'(limit));
            sender_calm = ($urandom_range(0, 3) == 0);

            // Load any relay entry the new count would search but nobody has written
            searched = (limit > TABLE_DEPTH) ? TABLE_DEPTH : limit;
            for (int unsigned i = 1; i <= searched; i++)
            begin
                if (!relay_loaded[i - 1])
                begin
                    nxt = random_item(limit, ignored);
                    nxt.operation = nnm_pkg::OP_LOAD_RELAY;
                    nxt.node_index = 9'(i);
                    send_item(nxt, 1'b0, NONE_FOUND);
                end
            end

            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                // switch between gappy and back-to-back stretches
                if (counted % 25 == 0)
                    sender_calm = ($urandom_range(0, 2) == 0);
                nxt = random_item(limit, ignored);
                if (!ignored)
                    counted++;
                send_item(nxt, 1'b0, NONE_FOUND);
            end
        end

        drain_block();
        if (mismatches == 0)
            $display("nearest_node_to_midpoint: match");
        else
            $display("nearest_node_to_midpoint: mismatch");
        $finish;
    end

    // Result side: random stalls per beat, calm stretches, and now and then a
    // long hold-off so that the output register fills and the item side stalls
    initial
    begin : result_sink
        int unsigned          gap;
        nnm_pkg::nnm_result_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            if (results_taken % 30 == 0)
                receiver_calm = ($urandom_range(0, 2) == 0);
            gap = receiver_calm ? 0 : $urandom_range(0, 5);
            if (results_taken % 200 == 50)
                gap = LONG_HOLD;
            if (gap != 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
            if (pending_nearest.size() == 0)
                report_mismatch("unexpected result beat, nearest_relay", result.nearest_relay, 0);
            else
            begin
                want = pending_nearest.pop_front();
                if (result.nearest_relay !== want.nearest_relay)
                    report_mismatch("nearest_relay", result.nearest_relay, want.nearest_relay);
                if (result.best_distance !== want.best_distance)
                    report_mismatch("best_distance", result.best_distance, want.best_distance);
                if (result.found !== want.found)
                    report_mismatch("found", result.found, want.found);
            end
            results_taken++;
        end
    end

    // Hard stop should the block hang
    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("nearest_node_to_midpoint: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/nnm_pkg.sv
hw/rtl/nnm_datapath.sv
hw/rtl/nnm_controller.sv
hw/rtl/nearest_node_to_midpoint.sv
dv/tb_nearest_node_to_midpoint.sv
